// File: rtl/plls_pkg.sv
// Shared types and constants for the predictive least-loaded selector.
// Sequencer state type, item kinds, register indexes and fixed-point constants.
// No dependencies.
package plls_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLOT,
        ST_RD,
        ST_ACC,
        ST_MULH,
        ST_DIV,
        ST_LFIN,
        ST_CFIN,
        ST_CMP1,
        ST_CMP2,
        ST_NEXT,
        ST_FIN,
        ST_OUT
    } state_t;

    localparam logic [1:0] KIND_UPDATE  = 2'd0;
    localparam logic [1:0] KIND_PREDICT = 2'd1;
    localparam logic [1:0] KIND_SELECT  = 2'd2;

    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_SMOOTH = 2'd1;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WINDOW = 2'd1;
    localparam logic [1:0] CFG_ALPHA  = 2'd2;

    localparam logic [16:0] CONF_ONE        = 17'd65536;
    localparam logic [16:0] CONF_SMOOTH_CAP = 17'd52429;
    localparam logic [16:0] CONF_FLOOR      = 17'd6554;
    localparam logic [16:0] ALPHA_RESET     = 17'd19661;
    localparam logic [1:0]  MODE_RESET      = MODE_LINEAR;

endpackage

// File: rtl/predictive_least_loaded_selector.sv
// Predictive least-loaded selector: per-slot load windows, trend or smoothing
// prediction, and least-weighted-load selection. Depends on plls_pkg.
//
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+----------------------------------------
// item in   | in        | start & !busy           | kind, server_index, load_sample,
//           |           |                         | horizon, available_mask
// result    | out       | done (one-cycle strobe) | forecast_load, confidence,
//           |           |                         | chosen_server, none_available
// config    | in        | cfg_write_en            | cfg_index, cfg_data
//
// An update item is written in the accept cycle and leaves the block idle.
// A predict item walks one window on a shared multiplier, then runs a bit-serial
// divider, for load and confidence in linear mode and for confidence alone when
// smoothing, with XW the load dividend width (58 by default).
// A select item walks the slots in turn from slot 0: each available slot is predicted
// and compared, one with no history counts as zero load, and masked-off slots are skipped.
// Reset restores the default configuration and clears sample counts and ring positions at once.
// The receiver cannot stall: each result shows for exactly one cycle.
module predictive_least_loaded_selector #(
    parameter int SERVER_SLOTS = 16,
    parameter int WINDOW_MAX   = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [3:0]         server_index,
    input  logic [15:0]        load_sample,
    input  logic [15:0]        horizon,
    input  logic [15:0]        available_mask,
    output logic               done,
    output logic signed [31:0] forecast_load,
    output logic [16:0]        confidence,
    output logic [3:0]         chosen_server,
    output logic               none_available,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data
);

    localparam int SW        = $clog2(SERVER_SLOTS);
    localparam int NW        = $clog2(WINDOW_MAX + 1);
    localparam int IW        = $clog2(WINDOW_MAX);
    localparam int CW        = 2 * NW + 1;
    localparam int NUMW      = 16 + CW + NW;
    localparam int DENW      = 4 * NW;
    localparam int DENAW     = DENW + 1;
    localparam int MAW       = (NUMW > 34) ? NUMW : 34;
    localparam int MBW       = 18;
    localparam int PW        = MAW + MBW;
    localparam int XW        = NUMW + 23;
    localparam int RW        = XW + 2;
    localparam int CONF_BITS = NW + 17;
    localparam int CNTW      = $clog2(XW + 1);
    localparam int DEPTH     = SERVER_SLOTS * WINDOW_MAX;
    localparam int AW        = $clog2(DEPTH);
    localparam int SEL_SLOTS = (SERVER_SLOTS < 16) ? SERVER_SLOTS : 16;
    localparam logic [NW-1:0] WL_RESET = NW'((WINDOW_MAX < 16) ? WINDOW_MAX : 16);
    localparam logic [AW-1:0] WMAX_A   = AW'(WINDOW_MAX);
    localparam logic [3:0]    SEL_LAST = 4'(SEL_SLOTS - 1);
    localparam logic signed [RW-1:0] SAT_HI = RW'(32'sh7fffffff);
    localparam logic signed [RW-1:0] SAT_LO = RW'(-32'sh7fffffff - 32'sh1);

    plls_pkg::state_t state_reg, state_next;

    // configuration and history bookkeeping
    logic [1:0]    mode_reg;
    logic [NW-1:0] wl_reg;
    logic [16:0]   alpha_reg;
    logic [NW-1:0] cnt_reg [SERVER_SLOTS];
    logic [IW-1:0] old_reg [SERVER_SLOTS];

    // sample store
    logic [15:0]   mem [DEPTH];
    logic [15:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;

    // latched item
    logic          sel_reg;
    logic [3:0]    slot_reg;
    logic [15:0]   horizon_reg;
    logic [15:0]   mask_reg;

    // window walk
    logic [NW-1:0]          n_reg;
    logic [NW-1:0]          i_reg;
    logic [IW-1:0]          pos_reg;
    logic signed [CW-1:0]   c_reg;
    logic signed [NUMW-1:0] num_reg;
    logic signed [DENAW-1:0] den_reg;
    logic [15:0]            last_reg;
    logic [31:0]            s_reg;

    // serial divider
    logic            neg_reg;
    logic            div_conf_reg;
    logic [DENW-1:0] div_rem_reg;
    logic [XW-1:0]   div_quo_reg;
    logic [DENW-1:0] div_den_reg;
    logic [CNTW-1:0] div_cnt_reg;

    // prediction and selection
    logic signed [31:0] load_reg;
    logic [16:0]        conf_reg;
    logic               found_reg;
    logic signed [31:0] best_load_reg;
    logic [16:0]        best_div_reg;
    logic [16:0]        best_conf_reg;
    logic [3:0]         best_slot_reg;
    logic signed [PW-1:0] cmp_reg;

    // result registers
    logic signed [31:0] pl_reg;
    logic [16:0]        cf_reg;
    logic [3:0]         cs_reg;
    logic               na_reg;

    logic                 accept;
    logic [SW-1:0]        cur_slot;
    logic                 slot_ok;
    logic [NW-1:0]        n_cur;
    logic [2*NW-1:0]      sx_prod;
    logic signed [CW-1:0] c_init;
    logic                 skip_slot;
    logic                 zero_slot;
    logic                 walk_end;
    logic [IW-1:0]        pos_inc;

    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [PW-1:0]  prod;
    logic [PW-1:0]         prod_abs;

    logic signed [33:0]   delta;
    logic signed [PW:0]   sm_round;
    logic signed [PW:0]   s_sum;
    logic [31:0]          s_new;

    logic [DENW:0]   div_shift;
    logic [DENW+1:0] div_trial;
    logic            div_ok;

    logic signed [RW-1:0] q_s;
    logic signed [RW-1:0] q_adj;
    logic signed [RW-1:0] lin_res;
    logic signed [31:0]   lin_load;
    logic [32:0]          sm_sum;
    logic signed [31:0]   load_calc;
    logic [CONF_BITS-1:0] conf_num;
    logic [17:0]          conf_q;
    logic [16:0]          conf_cap;
    logic [16:0]          conf_calc;
    logic [16:0]          cand_div;
    logic                 better;

    logic [SW-1:0]  upd_slot;
    logic           upd_ok;
    logic [NW-1:0]  upd_cnt;
    logic [IW-1:0]  upd_old;
    logic [NW:0]    upd_sum;
    logic [IW-1:0]  upd_pos;
    logic [IW-1:0]  upd_old_inc;
    logic [AW-1:0]  wr_addr;
    logic [NW-1:0]  wl_clamped;

    assign accept = start && !busy;

    // slot lookup for the walk
    assign cur_slot  = SW'(slot_reg);
    assign slot_ok   = 32'(slot_reg) < 32'(SERVER_SLOTS);
    assign n_cur     = cnt_reg[cur_slot];
    assign sx_prod   = (2 * NW)'(n_cur) * (2 * NW)'(n_cur - NW'(1));
    assign c_init    = -$signed({1'b0, sx_prod >> 1});
    assign skip_slot = sel_reg && !mask_reg[slot_reg];
    assign zero_slot = !slot_ok || (n_cur == '0)
                       || !((mode_reg == plls_pkg::MODE_LINEAR)
                            || (mode_reg == plls_pkg::MODE_SMOOTH));
    assign walk_end  = (i_reg == n_reg - NW'(1));
    assign pos_inc   = (NW'(pos_reg) + NW'(1) == wl_reg) ? '0 : pos_reg + IW'(1);
    assign rd_addr   = AW'(AW'(cur_slot) * WMAX_A + AW'(pos_reg));

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            plls_pkg::ST_RD:
            begin
                mul_a = MAW'(c_reg);
                mul_b = MBW'(i_reg);
            end
            plls_pkg::ST_ACC:
            begin
                if (mode_reg == plls_pkg::MODE_LINEAR)
                begin
                    mul_a = MAW'(c_reg);
                    mul_b = MBW'(rd_data_reg);
                end
                else
                begin
                    mul_a = MAW'(delta);
                    mul_b = MBW'(alpha_reg);
                end
            end
            plls_pkg::ST_MULH:
            begin
                mul_a = MAW'(num_reg);
                mul_b = MBW'(horizon_reg);
            end
            plls_pkg::ST_CMP1:
            begin
                mul_a = MAW'(load_reg);
                mul_b = MBW'(best_div_reg);
            end
            plls_pkg::ST_CMP2:
            begin
                mul_a = MAW'(best_load_reg);
                mul_b = MBW'(cand_div);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = PW'(mul_a) * PW'(mul_b);
    assign prod_abs = prod[PW-1] ? PW'(-prod) : PW'(prod);

    // smoothing step: s + round(alpha * (v - s))
    assign delta    = $signed({2'b00, rd_data_reg, 16'b0}) - $signed({2'b00, s_reg});
    assign sm_round = (PW + 1)'(prod) + (PW + 1)'(32768);
    assign s_sum    = $signed((PW + 1)'(s_reg)) + (sm_round >>> 16);
    assign s_new    = s_sum[31:0];

    // restoring divider step
    assign div_shift = {div_rem_reg, div_quo_reg[XW-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, div_den_reg};
    assign div_ok    = !div_trial[DENW+1];

    // finish the load: floor division sign fix, add last sample, saturate
    assign q_s     = $signed(RW'(div_quo_reg));
    assign q_adj   = neg_reg ? -(q_s + RW'(|div_rem_reg)) : q_s;
    assign lin_res = $signed(RW'({last_reg, 8'b0})) + q_adj;
    assign lin_load = (lin_res > SAT_HI) ? 32'sh7fffffff :
                      (lin_res < SAT_LO) ? (-32'sh7fffffff - 32'sh1) : 32'(lin_res);
    assign sm_sum    = 33'(s_reg) + 33'd128;
    assign load_calc = (mode_reg == plls_pkg::MODE_LINEAR) ? lin_load
                                                           : $signed(32'(sm_sum >> 8));

    // confidence: n/W or 2n/W, capped
    assign conf_num  = (mode_reg == plls_pkg::MODE_SMOOTH) ? {n_reg, 17'b0}
                                                           : {1'b0, n_reg, 16'b0};
    assign conf_q    = div_quo_reg[17:0];
    assign conf_cap  = (mode_reg == plls_pkg::MODE_LINEAR) ? plls_pkg::CONF_ONE
                                                           : plls_pkg::CONF_SMOOTH_CAP;
    assign conf_calc = ({1'b0, conf_cap} < conf_q) ? conf_cap : conf_q[16:0];
    assign cand_div  = (conf_reg < plls_pkg::CONF_FLOOR) ? plls_pkg::CONF_FLOOR : conf_reg;
    assign better    = !found_reg || (cmp_reg < prod);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plls_pkg::ST_IDLE:
            begin
                if (accept && (kind inside {plls_pkg::KIND_PREDICT, plls_pkg::KIND_SELECT}))
                    state_next = plls_pkg::ST_SLOT;
            end
            plls_pkg::ST_SLOT:
            begin
                if (skip_slot)
                    state_next = plls_pkg::ST_NEXT;
                else if (zero_slot)
                    state_next = sel_reg ? plls_pkg::ST_CMP1 : plls_pkg::ST_FIN;
                else
                    state_next = plls_pkg::ST_RD;
            end
            plls_pkg::ST_RD:
                state_next = plls_pkg::ST_ACC;
            plls_pkg::ST_ACC:
            begin
                if (!walk_end)
                    state_next = plls_pkg::ST_RD;
                else if (mode_reg == plls_pkg::MODE_LINEAR)
                    state_next = plls_pkg::ST_MULH;
                else
                    state_next = plls_pkg::ST_LFIN;
            end
            plls_pkg::ST_MULH:
                state_next = plls_pkg::ST_DIV;
            plls_pkg::ST_DIV:
            begin
                if (div_cnt_reg == CNTW'(1))
                    state_next = div_conf_reg ? plls_pkg::ST_CFIN : plls_pkg::ST_LFIN;
            end
            plls_pkg::ST_LFIN:
                state_next = plls_pkg::ST_DIV;
            plls_pkg::ST_CFIN:
                state_next = sel_reg ? plls_pkg::ST_CMP1 : plls_pkg::ST_FIN;
            plls_pkg::ST_CMP1:
                state_next = plls_pkg::ST_CMP2;
            plls_pkg::ST_CMP2:
                state_next = plls_pkg::ST_NEXT;
            plls_pkg::ST_NEXT:
                state_next = (slot_reg == SEL_LAST) ? plls_pkg::ST_FIN : plls_pkg::ST_SLOT;
            plls_pkg::ST_FIN:
                state_next = plls_pkg::ST_OUT;
            plls_pkg::ST_OUT:
                state_next = plls_pkg::ST_IDLE;
            default:
                state_next = plls_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        busy = (state_reg != plls_pkg::ST_IDLE);
        done = (state_reg == plls_pkg::ST_OUT);
    end

    assign forecast_load  = pl_reg;
    assign confidence     = cf_reg;
    assign chosen_server  = cs_reg;
    assign none_available = na_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= plls_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // update bookkeeping
    assign upd_slot    = SW'(server_index);
    assign upd_ok      = 32'(server_index) < 32'(SERVER_SLOTS);
    assign upd_cnt     = cnt_reg[upd_slot];
    assign upd_old     = old_reg[upd_slot];
    assign upd_sum     = (NW + 1)'(upd_old) + (NW + 1)'(upd_cnt);
    assign upd_pos     = (upd_cnt < wl_reg)
                         ? ((upd_sum >= (NW + 1)'(wl_reg)) ? IW'(upd_sum - (NW + 1)'(wl_reg))
                                                           : IW'(upd_sum))
                         : upd_old;
    assign upd_old_inc = (NW'(upd_old) + NW'(1) == wl_reg) ? '0 : upd_old + IW'(1);
    assign wr_addr     = AW'(AW'(upd_slot) * WMAX_A + AW'(upd_pos));
    assign wl_clamped  = (cfg_data[5:0] == 6'd0) ? NW'(1) :
                         (32'(cfg_data[5:0]) > 32'(WINDOW_MAX)) ? NW'(WINDOW_MAX)
                                                                : NW'(cfg_data[5:0]);

    // configuration writes and history counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= plls_pkg::MODE_RESET;
            wl_reg    <= WL_RESET;
            alpha_reg <= plls_pkg::ALPHA_RESET;
            for (int k = 0; k < SERVER_SLOTS; k++)
            begin
                cnt_reg[k] <= '0;
                old_reg[k] <= '0;
            end
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                plls_pkg::CFG_MODE:
                    mode_reg <= cfg_data[1:0];
                plls_pkg::CFG_WINDOW:
                begin
                    wl_reg <= wl_clamped;
                    for (int k = 0; k < SERVER_SLOTS; k++)
                    begin
                        cnt_reg[k] <= '0;
                        old_reg[k] <= '0;
                    end
                end
                plls_pkg::CFG_ALPHA:
                    alpha_reg <= (cfg_data > plls_pkg::CONF_ONE) ? plls_pkg::CONF_ONE
                                                                 : cfg_data;
                default:
                    mode_reg <= mode_reg;
            endcase
        end
        else if (accept && (kind == plls_pkg::KIND_UPDATE) && upd_ok)
        begin
            if (upd_cnt < wl_reg)
                cnt_reg[upd_slot] <= upd_cnt + NW'(1);
            else
                old_reg[upd_slot] <= upd_old_inc;
        end
    end

    // sample store write and registered read
    always_ff @(posedge clk)
    begin
        if (accept && (kind == plls_pkg::KIND_UPDATE) && upd_ok)
            mem[wr_addr] <= load_sample;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    // datapath under the sequencer
    always_ff @(posedge clk)
    begin
        case (state_reg)
            plls_pkg::ST_IDLE:
            begin
                sel_reg     <= (kind == plls_pkg::KIND_SELECT);
                slot_reg    <= (kind == plls_pkg::KIND_SELECT) ? 4'd0 : server_index;
                horizon_reg <= horizon;
                mask_reg    <= available_mask;
                found_reg   <= 1'b0;
            end
            plls_pkg::ST_SLOT:
            begin
                n_reg   <= n_cur;
                pos_reg <= old_reg[cur_slot];
                i_reg   <= '0;
                c_reg   <= c_init;
                num_reg <= '0;
                den_reg <= '0;
                if (zero_slot)
                begin
                    load_reg <= '0;
                    conf_reg <= '0;
                end
            end
            plls_pkg::ST_RD:
                den_reg <= den_reg + DENAW'(prod);
            plls_pkg::ST_ACC:
            begin
                num_reg  <= num_reg + NUMW'(prod);
                s_reg    <= (i_reg == '0) ? {rd_data_reg, 16'b0} : s_new;
                last_reg <= rd_data_reg;
                i_reg    <= i_reg + NW'(1);
                c_reg    <= c_reg + $signed(CW'(n_reg));
                pos_reg  <= pos_inc;
            end
            plls_pkg::ST_MULH:
            begin
                neg_reg      <= prod[PW-1];
                div_quo_reg  <= XW'(prod_abs) << 8;
                div_rem_reg  <= '0;
                div_den_reg  <= (n_reg < NW'(2)) ? DENW'(1) : DENW'(den_reg);
                div_cnt_reg  <= CNTW'(XW);
                div_conf_reg <= 1'b0;
            end
            plls_pkg::ST_DIV:
            begin
                div_rem_reg <= div_ok ? div_trial[DENW-1:0] : div_shift[DENW-1:0];
                div_quo_reg <= {div_quo_reg[XW-2:0], div_ok};
                div_cnt_reg <= div_cnt_reg - CNTW'(1);
            end
            plls_pkg::ST_LFIN:
            begin
                load_reg     <= load_calc;
                div_quo_reg  <= XW'(conf_num) << (XW - CONF_BITS);
                div_rem_reg  <= '0;
                div_den_reg  <= DENW'(wl_reg);
                div_cnt_reg  <= CNTW'(CONF_BITS);
                div_conf_reg <= 1'b1;
            end
            plls_pkg::ST_CFIN:
                conf_reg <= conf_calc;
            plls_pkg::ST_CMP1:
                cmp_reg <= prod;
            plls_pkg::ST_CMP2:
            begin
                if (better)
                begin
                    found_reg     <= 1'b1;
                    best_load_reg <= load_reg;
                    best_div_reg  <= cand_div;
                    best_conf_reg <= conf_reg;
                    best_slot_reg <= slot_reg;
                end
            end
            plls_pkg::ST_NEXT:
                slot_reg <= slot_reg + 4'd1;
            plls_pkg::ST_FIN:
            begin
                if (!sel_reg)
                begin
                    pl_reg <= load_reg;
                    cf_reg <= conf_reg;
                    cs_reg <= slot_reg;
                    na_reg <= 1'b0;
                end
                else if (found_reg)
                begin
                    pl_reg <= best_load_reg;
                    cf_reg <= best_conf_reg;
                    cs_reg <= best_slot_reg;
                    na_reg <= 1'b0;
                end
                else
                begin
                    pl_reg <= '0;
                    cf_reg <= '0;
                    cs_reg <= '0;
                    na_reg <= 1'b1;
                end
            end
            default:
                found_reg <= found_reg;
        endcase
    end

    // checks
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held longer than one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == plls_pkg::KIND_PREDICT || kind == plls_pkg::KIND_SELECT))
        |=> busy)
        else $error("predict or select item did not start the sequencer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && none_available) |-> (forecast_load == 32'sd0 && confidence == 17'd0
                                      && chosen_server == 4'd0))
        else $error("empty select result carries a nonzero payload");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (confidence <= plls_pkg::CONF_ONE))
        else $error("confidence above one");

endmodule
